/* src/rmth_pkg.sv */
package rmth_pkg;

  localparam int CAPACITY_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // datapath operation codes
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_ACCEPT = 4'd1;
  localparam logic [3:0] OP_DROP   = 4'd2;
  localparam logic [3:0] OP_SWAP   = 4'd3;
  localparam logic [3:0] OP_PUSH   = 4'd4;
  localparam logic [3:0] OP_POP    = 4'd5;
  localparam logic [3:0] OP_POPLD  = 4'd6;
  localparam logic [3:0] OP_SDL    = 4'd7;
  localparam logic [3:0] OP_SDR    = 4'd8;
  localparam logic [3:0] OP_SDD    = 4'd9;
  localparam logic [3:0] OP_SUC    = 4'd10;
  localparam logic [3:0] OP_SUD    = 4'd11;
  localparam logic [3:0] OP_OUT    = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       sel_u;  // 1: upper (min) heap, 0: lower (max) heap
  } cmd_t;

  typedef struct packed {
    logic full;      // store holds CAPACITY samples
    logic over;      // count above CAPACITY (never expected)
    logic swap;      // sample belongs above the upper heap's top
    logic sd_leaf;   // sift-down position has no left child
    logic sd_stop;   // sift-down value stays at this position
    logic su_root;   // sift-up reached the root
    logic su_stop;   // sift-up value stays at this position
    logic l_gt_u;    // lower heap larger than upper heap
    logic balanced;  // upper size equals lower size or lower size plus one
    logic out_free;  // output register can take a new word
  } sts_t;

endpackage

/* src/rmth_dp.sv */
module rmth_dp #(
  parameter int CAPACITY     = rmth_pkg::CAPACITY_DEF,
  parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF,
  parameter int CNTW         = $clog2(CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rmth_pkg::cmd_t                 cmd,
  output rmth_pkg::sts_t                 sts,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH:0]   out_median_twice,
  output logic [CNTW-1:0]                out_held_count,
  output logic                           out_dropped
);
  import rmth_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int HDEPTH = CAPACITY / 2 + 1;
  localparam int IW     = $clog2(HDEPTH);
  localparam int SZW    = $clog2(HDEPTH + 1);
  localparam int XW     = IW + 2;

  logic signed [SW-1:0] lo_heap_r [2**IW];
  logic signed [SW-1:0] up_heap_r [2**IW];
  logic signed [SW-1:0] rdl_r, rdu_r;

  logic signed [SW-1:0] x_r, x_nxt, v_r, v_nxt, a_r, a_nxt;
  logic signed [SW-1:0] top_l_r, top_l_nxt, top_u_r, top_u_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic [SZW-1:0]       size_l_r, size_l_nxt, size_u_r, size_u_nxt;
  logic                 drop_r, drop_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW:0]   out_med_r, out_med_nxt;
  logic [CNTW-1:0]      out_cnt_r, out_cnt_nxt;
  logic                 out_drop_r, out_drop_nxt;

  logic                 wr_en, rd_en;
  logic [IW-1:0]        wr_addr, rd_addr;
  logic signed [SW-1:0] wr_data, rdata, bestv;
  logic [XW-1:0]        left_x, right_x, n_x;
  logic [IW-1:0]        parent;
  logic [CNTW-1:0]      total;
  logic                 pick_l, pick_r;
  logic signed [SW:0]   med;

  function automatic logic above(input logic signed [SW-1:0] a,
                                 input logic signed [SW-1:0] b,
                                 input logic                 min_heap);
    above = min_heap ? (a < b) : (a > b);
  endfunction

  assign rdata   = cmd.sel_u ? rdu_r : rdl_r;
  assign n_x     = XW'(cmd.sel_u ? size_u_r : size_l_r);
  assign left_x  = {1'b0, pos_r, 1'b1};
  assign right_x = left_x + XW'(1);
  assign parent  = IW'((pos_r - 1'b1) >> 1);
  assign total   = CNTW'(size_l_r) + CNTW'(size_u_r);

  assign pick_l = above(a_r, v_r, cmd.sel_u);
  assign bestv  = pick_l ? a_r : v_r;
  assign pick_r = (right_x < n_x) && above(rdata, bestv, cmd.sel_u);

  assign sts.full     = total >= CNTW'(CAPACITY);
  assign sts.over     = total > CNTW'(CAPACITY);
  assign sts.swap     = (size_u_r != '0) && (x_r > top_u_r);
  assign sts.sd_leaf  = left_x >= n_x;
  assign sts.sd_stop  = !pick_l && !pick_r;
  assign sts.su_root  = pos_r == '0;
  assign sts.su_stop  = !above(v_r, rdata, cmd.sel_u);
  assign sts.l_gt_u   = size_l_r > size_u_r;
  assign sts.balanced = (size_u_r == size_l_r) || (size_u_r == size_l_r + 1'b1);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (total == '0) begin
      med = '0;
    end else if (size_l_r == size_u_r) begin
      med = {top_l_r[SW-1], top_l_r} + {top_u_r[SW-1], top_u_r};
    end else begin
      med = {top_u_r, 1'b0};
    end
  end

  always_comb begin
    x_nxt = x_r;  v_nxt = v_r;  a_nxt = a_r;  pos_nxt = pos_r;
    size_l_nxt = size_l_r;  size_u_nxt = size_u_r;  drop_nxt = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_med_nxt = out_med_r;  out_cnt_nxt = out_cnt_r;  out_drop_nxt = out_drop_r;
    wr_en = 1'b0;  wr_addr = pos_r;  wr_data = v_r;
    rd_en = 1'b0;  rd_addr = IW'(left_x);
    case (cmd.op)
      OP_ACCEPT: begin
        x_nxt    = in_sample;
        drop_nxt = 1'b0;
        if (in_restart) begin
          size_l_nxt = '0;
          size_u_nxt = '0;
        end
      end
      OP_DROP: drop_nxt = 1'b1;
      OP_SWAP: begin
        v_nxt   = x_r;
        x_nxt   = top_u_r;
        pos_nxt = '0;
      end
      OP_PUSH: begin
        v_nxt = x_r;
        if (cmd.sel_u) begin
          pos_nxt    = IW'(size_u_r);
          size_u_nxt = size_u_r + 1'b1;
        end else begin
          pos_nxt    = IW'(size_l_r);
          size_l_nxt = size_l_r + 1'b1;
        end
      end
      OP_POP: begin
        x_nxt      = top_l_r;
        size_l_nxt = size_l_r - 1'b1;
        rd_en      = 1'b1;
        rd_addr    = IW'(size_l_r - 1'b1);
      end
      OP_POPLD: begin
        v_nxt   = rdata;
        pos_nxt = '0;
      end
      OP_SDL: begin
        if (sts.sd_leaf) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      OP_SDR: begin
        a_nxt   = rdata;
        rd_en   = 1'b1;
        rd_addr = IW'(right_x);
      end
      OP_SDD: begin
        wr_en = 1'b1;
        if (pick_r) begin
          wr_data = rdata;
          pos_nxt = IW'(right_x);
        end else if (pick_l) begin
          wr_data = a_r;
          pos_nxt = IW'(left_x);
        end
      end
      OP_SUC: begin
        if (sts.su_root) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      OP_SUD: begin
        wr_en = 1'b1;
        if (!sts.su_stop) begin
          wr_data = rdata;
          pos_nxt = parent;
        end
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_med_nxt   = med;
        out_cnt_nxt   = total;
        out_drop_nxt  = drop_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    top_l_nxt = top_l_r;
    top_u_nxt = top_u_r;
    if (wr_en && wr_addr == '0) begin
      if (cmd.sel_u) begin
        top_u_nxt = wr_data;
      end else begin
        top_l_nxt = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !cmd.sel_u) begin
      lo_heap_r[wr_addr] <= wr_data;
    end
    if (rd_en && !cmd.sel_u) begin
      rdl_r <= lo_heap_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && cmd.sel_u) begin
      up_heap_r[wr_addr] <= wr_data;
    end
    if (rd_en && cmd.sel_u) begin
      rdu_r <= up_heap_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_l_r    <= '0;
      size_u_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      size_l_r    <= size_l_nxt;
      size_u_r    <= size_u_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    v_r        <= v_nxt;
    a_r        <= a_nxt;
    pos_r      <= pos_nxt;
    top_l_r    <= top_l_nxt;
    top_u_r    <= top_u_nxt;
    out_med_r  <= out_med_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_twice = out_med_r;
  assign out_held_count   = out_cnt_r;
  assign out_dropped      = out_drop_r;

endmodule

/* src/rmth_ctrl.sv */
module rmth_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rmth_pkg::sts_t sts,
  output rmth_pkg::cmd_t cmd
);
  import rmth_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SDL    = 4'd2;
  localparam logic [3:0] S_SDR    = 4'd3;
  localparam logic [3:0] S_SDD    = 4'd4;
  localparam logic [3:0] S_SUC    = 4'd5;
  localparam logic [3:0] S_SUD    = 4'd6;
  localparam logic [3:0] S_PUSHL  = 4'd7;
  localparam logic [3:0] S_POPCHK = 4'd8;
  localparam logic [3:0] S_POPW   = 4'd9;
  localparam logic [3:0] S_PUSHU  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  // which sift is running, and so what follows it
  localparam logic [1:0] PH_UDOWN = 2'd0;
  localparam logic [1:0] PH_LUP   = 2'd1;
  localparam logic [1:0] PH_LDOWN = 2'd2;
  localparam logic [1:0] PH_UUP   = 2'd3;

  logic [3:0] state_r, state_nxt, after_sift;
  logic [1:0] phase_r, phase_nxt;

  always_comb begin
    case (phase_r)
      PH_UDOWN: after_sift = S_PUSHL;
      PH_LUP:   after_sift = S_POPCHK;
      PH_LDOWN: after_sift = S_PUSHU;
      default:  after_sift = S_DONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd.op    = OP_NONE;
    cmd.sel_u = (phase_r == PH_UDOWN) || (phase_r == PH_UUP);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.full) begin
          cmd.op    = OP_DROP;
          state_nxt = S_DONE;
        end else if (sts.swap) begin
          cmd.op    = OP_SWAP;
          phase_nxt = PH_UDOWN;
          state_nxt = S_SDL;
        end else begin
          state_nxt = S_PUSHL;
        end
      end
      S_SDL: begin
        cmd.op    = OP_SDL;
        state_nxt = sts.sd_leaf ? after_sift : S_SDR;
      end
      S_SDR: begin
        cmd.op    = OP_SDR;
        state_nxt = S_SDD;
      end
      S_SDD: begin
        cmd.op    = OP_SDD;
        state_nxt = sts.sd_stop ? after_sift : S_SDL;
      end
      S_SUC: begin
        cmd.op    = OP_SUC;
        state_nxt = sts.su_root ? after_sift : S_SUD;
      end
      S_SUD: begin
        cmd.op    = OP_SUD;
        state_nxt = sts.su_stop ? after_sift : S_SUC;
      end
      S_PUSHL: begin
        cmd.op    = OP_PUSH;
        cmd.sel_u = 1'b0;
        phase_nxt = PH_LUP;
        state_nxt = S_SUC;
      end
      S_POPCHK: begin
        cmd.sel_u = 1'b0;
        if (sts.l_gt_u) begin
          cmd.op    = OP_POP;
          phase_nxt = PH_LDOWN;
          state_nxt = S_POPW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POPW: begin
        cmd.op    = OP_POPLD;
        cmd.sel_u = 1'b0;
        state_nxt = S_SDL;
      end
      S_PUSHU: begin
        cmd.op    = OP_PUSH;
        cmd.sel_u = 1'b1;
        phase_nxt = PH_UUP;
        state_nxt = S_SUC;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_UUP;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  a_idle_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> sts.balanced)
    else $error("heap sizes out of balance between words");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.over)
    else $error("held count above capacity");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_CHECK))
    else $error("accepted word did not reach the capacity check");

endmodule

/* src/running_median_two_heaps_core.sv */
// Running median over all samples since reset or the last restart. Each input
// word inserts one signed sample (restart empties the set first) and yields one
// output word: twice the median (low bit is the half), the number of samples
// held, and a dropped flag set when CAPACITY samples were already held, in which
// case the set is left as is. The set lives in two single-port heap memories of
// 2**clog2(CAPACITY/2+1) entries each: a max-heap of the lower half and a
// min-heap of the upper half, which holds the extra sample on odd counts. One
// word is worked at a time; it finishes sooner when the sample settles early.
// The cost is set by the heap memories' single registered read port: a sift-down
// level reads the left child, reads the right child and then writes, a sift-up
// level reads the parent and then writes, and an insert runs up to two of each.
// The input stalls from the accept until the result is loaded in the output
// register; a result waiting there does not block the next accept.
module running_median_two_heaps_core #(
  parameter int CAPACITY     = rmth_pkg::CAPACITY_DEF,
  parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF,
  parameter int CNTW         = $clog2(CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH:0]   out_median_twice,
  output logic [CNTW-1:0]                out_held_count,
  output logic                           out_dropped
);
  import rmth_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the capacity check, sifts and output load
  rmth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold both heaps, their sizes and tops, and the output word
  rmth_dp #(
    .CAPACITY     (CAPACITY),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CNTW         (CNTW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_twice (out_median_twice),
    .out_held_count   (out_held_count),
    .out_dropped      (out_dropped)
  );

endmodule
